/* hw/rtl/assert_macros.svh */
// assertion macros for the rtl files that check themselves
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define DTP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define DTP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/dtp_pkg.sv */
// types, constants and helper functions of the dithered tile packer
package dtp_pkg;

    // tile geometry
    localparam int TILE_EDGE   = 8;
    localparam int TILE_PIXELS = TILE_EDGE * TILE_EDGE;
    localparam int POS_W       = $clog2(TILE_PIXELS);
    localparam int COORD_W     = $clog2(TILE_EDGE);
    localparam logic [POS_W-1:0]   LAST_POS = POS_W'(TILE_PIXELS - 1);
    localparam logic [COORD_W-1:0] LAST_COL = COORD_W'(TILE_EDGE - 1);

    // input field widths
    localparam int CHAN_W   = 8;
    localparam int ORIGIN_W = 10;
    localparam int FRAME_W  = 3;
    localparam int MAX_IMAGE_EDGE = 1024;

    // shade register
    localparam int SHADE_W = 3;
    localparam logic [SHADE_W-1:0] SHADES_MIN   = SHADE_W'(2);
    localparam logic [SHADE_W-1:0] SHADES_MAX   = SHADE_W'(6);
    localparam logic [SHADE_W-1:0] SHADES_RESET = SHADE_W'(2);

    // alpha threshold for the mask bit
    localparam logic [CHAN_W-1:0] ALPHA_HALF = CHAN_W'(128);

    // grey = (r+g+b)/3 as multiply by reciprocal, exact for sums up to 765
    localparam int RGB_SUM_W   = CHAN_W + 2;
    localparam int GREY_RECIP_W = 10;
    localparam logic [GREY_RECIP_W-1:0] GREY_RECIP = GREY_RECIP_W'(683);
    localparam int GREY_SHIFT  = 11;
    localparam int GREY_PROD_W = RGB_SUM_W + GREY_RECIP_W;

    // dither phase sum: col + row + two origins + frame
    localparam int PHASE_SUM_W = ORIGIN_W + 2;
    localparam int RECIP_W     = 17;
    localparam int RECIP_SHIFT = 16;
    localparam int QUOT_PROD_W = PHASE_SUM_W + RECIP_W;

    // threshold product grey * shades
    localparam int THR_PROD_W = CHAN_W + SHADE_W;

    // stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // tile queue depth default
    localparam int QUEUE_DEPTH_DEF = 2;

    typedef logic [TILE_EDGE-1:0] col_byte_t;

    typedef struct packed {
        col_byte_t [TILE_EDGE-1:0] draw;
        col_byte_t [TILE_EDGE-1:0] mask;
    } tile_t;

    typedef struct packed {
        logic  valid;
        tile_t tile;
    } tile_push_t;

    // clamp the shade count into its legal range
    function automatic logic [SHADE_W-1:0] clamp_shades(input logic [SHADE_W-1:0] n);
        logic [SHADE_W-1:0] s;
        s = n;
        if (n < SHADES_MIN)
            s = SHADES_MIN;
        else if (n > SHADES_MAX)
            s = SHADES_MAX;
        return s;
    endfunction

    // scaled reciprocal of the dither modulus, 2^16 / m rounded up
    function automatic logic [RECIP_W-1:0] modulus_recip(input logic [SHADE_W-1:0] m);
        logic [RECIP_W-1:0] r;
        case (m)
            3'd1:    r = RECIP_W'(65536);
            3'd2:    r = RECIP_W'(32768);
            3'd3:    r = RECIP_W'(21846);
            3'd4:    r = RECIP_W'(16384);
            3'd5:    r = RECIP_W'(13108);
            default: r = RECIP_W'(65536);
        endcase
        return r;
    endfunction

endpackage

/* hw/rtl/dtp_front.sv */
// front end: accepts pixels, classifies draw and mask bits, builds the tile store
module dtp_front (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write: shade count
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dtp_pkg::SHADE_W-1:0]   cfg_data,
    // pixel stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [dtp_pkg::S_TDATA_W-1:0] s_tdata,
    // tile queue
    input  logic                          queue_full,
    output dtp_pkg::tile_push_t           tile_push
);
    import dtp_pkg::*;

    // unpacked input fields
    logic [CHAN_W-1:0]      in_red;
    logic [CHAN_W-1:0]      in_green;
    logic [CHAN_W-1:0]      in_blue;
    logic [CHAN_W-1:0]      in_alpha;
    logic [ORIGIN_W-1:0]    in_origin_x;
    logic [ORIGIN_W-1:0]    in_origin_y;
    logic [FRAME_W-1:0]     in_frame;
    logic [ORIGIN_W-1:0]    origin_x_mod;
    logic [ORIGIN_W-1:0]    origin_y_mod;
    logic                   accept;

    // control registers
    logic [SHADE_W-1:0]     shades_reg, shades_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic                   s1_valid_reg, s2_valid_reg;

    // stage one payload
    logic [RGB_SUM_W-1:0]   s1_rgb_sum_reg, s1_rgb_sum_next;
    logic [PHASE_SUM_W-1:0] s1_phase_sum_reg, s1_phase_sum_next;
    logic                   s1_mask_reg, s1_mask_next;
    logic [POS_W-1:0]       s1_pos_reg;
    logic [SHADE_W-1:0]     s1_shades_reg, s1_shades_next;

    // stage two payload
    logic [GREY_PROD_W-1:0] grey_prod;
    logic [QUOT_PROD_W-1:0] quot_prod;
    logic [SHADE_W-1:0]     s1_modulus;
    logic [CHAN_W-1:0]      s2_grey_reg, s2_grey_next;
    logic [PHASE_SUM_W-1:0] s2_quot_reg, s2_quot_next;
    logic [PHASE_SUM_W-1:0] s2_phase_sum_reg;
    logic [SHADE_W-1:0]     s2_modulus_reg;
    logic [SHADE_W-1:0]     s2_shades_reg;
    logic                   s2_mask_reg;
    logic [POS_W-1:0]       s2_pos_reg;

    // stage three: compare and store
    logic [THR_PROD_W-1:0]              thr_prod;
    logic [PHASE_SUM_W+SHADE_W-1:0]     qm_prod;
    logic [PHASE_SUM_W-1:0]             phase_diff;
    logic [SHADE_W-1:0]                 threshold;
    logic [SHADE_W-1:0]                 phase;
    logic                               draw_bit;
    logic [COORD_W-1:0]                 s2_col;
    logic [COORD_W-1:0]                 s2_row;
    logic                               tile_done;
    tile_t                              store_reg, store_next;

    // field unpack, lowest field first
    assign in_red      = s_tdata[7:0];
    assign in_green    = s_tdata[15:8];
    assign in_blue     = s_tdata[23:16];
    assign in_alpha    = s_tdata[31:24];
    assign in_origin_x = s_tdata[41:32];
    assign in_origin_y = s_tdata[51:42];
    assign in_frame    = s_tdata[54:52];

    assign origin_x_mod = ORIGIN_W'(in_origin_x % MAX_IMAGE_EDGE);
    assign origin_y_mod = ORIGIN_W'(in_origin_y % MAX_IMAGE_EDGE);

    // hold off the final pixel of a tile while the queue has no slot
    assign s_tready  = !((pos_reg == LAST_POS) && queue_full);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // stage one: sums and position bookkeeping
    always_comb
    begin
        shades_next = shades_reg;
        if (cfg_valid)
            shades_next = cfg_data;
        pos_next = pos_reg;
        if (accept)
            pos_next = pos_reg + 1'b1;
        s1_rgb_sum_next = RGB_SUM_W'(in_red) + RGB_SUM_W'(in_green) + RGB_SUM_W'(in_blue);
        s1_phase_sum_next = PHASE_SUM_W'(pos_reg[COORD_W-1:0])
                          + PHASE_SUM_W'(pos_reg[POS_W-1:COORD_W])
                          + PHASE_SUM_W'(origin_x_mod)
                          + PHASE_SUM_W'(origin_y_mod)
                          + PHASE_SUM_W'(in_frame);
        s1_mask_next   = in_alpha < ALPHA_HALF;
        s1_shades_next = clamp_shades(shades_reg);
    end

    // stage two: grey level and phase quotient by reciprocal multiply
    always_comb
    begin
        s1_modulus   = s1_shades_reg - 1'b1;
        grey_prod    = GREY_PROD_W'(s1_rgb_sum_reg) * GREY_PROD_W'(GREY_RECIP);
        quot_prod    = QUOT_PROD_W'(s1_phase_sum_reg) * QUOT_PROD_W'(modulus_recip(s1_modulus));
        s2_grey_next = grey_prod[GREY_SHIFT +: CHAN_W];
        s2_quot_next = quot_prod[RECIP_SHIFT +: PHASE_SUM_W];
    end

    // stage three: threshold, phase remainder, bit merge into the store
    always_comb
    begin
        s2_col     = s2_pos_reg[COORD_W-1:0];
        s2_row     = s2_pos_reg[POS_W-1:COORD_W];
        thr_prod   = THR_PROD_W'(s2_grey_reg) * THR_PROD_W'(s2_shades_reg);
        threshold  = thr_prod[THR_PROD_W-1:CHAN_W];
        qm_prod    = (PHASE_SUM_W+SHADE_W)'(s2_quot_reg)
                   * (PHASE_SUM_W+SHADE_W)'(s2_modulus_reg);
        phase_diff = s2_phase_sum_reg - qm_prod[PHASE_SUM_W-1:0];
        phase      = phase_diff[SHADE_W-1:0];
        draw_bit   = phase >= threshold;
        tile_done  = s2_valid_reg && (s2_pos_reg == LAST_POS);
        store_next = store_reg;
        if (s2_valid_reg)
        begin
            store_next.draw[s2_col][s2_row] = store_reg.draw[s2_col][s2_row] | draw_bit;
            store_next.mask[s2_col][s2_row] = store_reg.mask[s2_col][s2_row] | s2_mask_reg;
        end
        tile_push.valid = tile_done;
        tile_push.tile  = store_next;
    end

    // control state and the tile store
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shades_reg   <= SHADES_RESET;
            pos_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            store_reg    <= '0;
        end
        else
        begin
            shades_reg   <= shades_next;
            pos_reg      <= pos_next;
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
            if (tile_done)
                store_reg <= '0;
            else
                store_reg <= store_next;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_rgb_sum_reg   <= s1_rgb_sum_next;
            s1_phase_sum_reg <= s1_phase_sum_next;
            s1_mask_reg      <= s1_mask_next;
            s1_pos_reg       <= pos_reg;
            s1_shades_reg    <= s1_shades_next;
        end
        s2_grey_reg      <= s2_grey_next;
        s2_quot_reg      <= s2_quot_next;
        s2_phase_sum_reg <= s1_phase_sum_reg;
        s2_modulus_reg   <= s1_modulus;
        s2_shades_reg    <= s1_shades_reg;
        s2_mask_reg      <= s1_mask_reg;
        s2_pos_reg       <= s1_pos_reg;
    end

endmodule

/* hw/rtl/dtp_queue.sv */
// short queue of finished tiles between the front and back ends
module dtp_queue #(
    parameter int DEPTH = dtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  dtp_pkg::tile_push_t tile_push,
    output logic                full,
    output logic                head_valid,
    output dtp_pkg::tile_t      head_tile,
    input  logic                pop
);
    import dtp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tile_t              entries [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_tile  = entries[rd_ptr_reg];
    assign do_push    = tile_push.valid && !full;
    assign do_pop     = pop && head_valid;

    // pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // tile storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entries[wr_ptr_reg] <= tile_push.tile;
    end

endmodule

/* hw/rtl/dtp_back.sv */
// back end: walks the head tile column by column into the output register
module dtp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          head_valid,
    input  dtp_pkg::tile_t                head_tile,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [dtp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import dtp_pkg::*;

    logic [COORD_W-1:0] col_reg, col_next;
    logic               out_valid_reg, out_valid_next;
    logic [COORD_W-1:0] out_col_reg;
    col_byte_t          out_draw_reg;
    col_byte_t          out_mask_reg;
    logic               out_last_reg;
    logic               load;

    // load the next column whenever a head tile is present and the output register is free or draining
    always_comb
    begin
        load = head_valid && (!out_valid_reg || m_tready);
        pop  = load && (col_reg == LAST_COL);
        col_next = col_reg;
        if (load)
            col_next = col_reg + 1'b1;
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_col_reg  <= col_reg;
            out_draw_reg <= head_tile.draw[col_reg];
            out_mask_reg <= head_tile.mask[col_reg];
            out_last_reg <= col_reg == LAST_COL;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b0, out_mask_reg, out_draw_reg, out_col_reg};
    assign m_tlast  = out_last_reg;

endmodule

/* hw/rtl/dithered_tile_packer.sv */
// Pixels are taken one per cycle; the final pixel of a tile waits only while the tile queue is full.
// A pixel passes a three-stage classify pipeline (sums, reciprocal multiplies, compare and merge).
// The 64th pixel's tile passes the stage one and stage two registers into the queue; its eight column
// transactions then leave one per cycle through the output register while m_tready stays high.
// Throughput: one pixel per cycle in while the queue has room, one column per cycle out while m_tready is high.
// Reset clears the position, the tile store, the queue and the output; shade count returns to 2.
`include "assert_macros.svh"

module dithered_tile_packer #(
    parameter int QUEUE_DEPTH = dtp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // shade count write
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [dtp_pkg::SHADE_W-1:0]   cfg_data,
    // pixels
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], tile_origin_x[41:32],
    // tile_origin_y[51:42], frame_number[54:52], zero pad[55]
    input  logic [dtp_pkg::S_TDATA_W-1:0] s_tdata,
    // column results, tlast is last_column
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // column[2:0], draw_byte[10:3], mask_byte[18:11], zero pad[23:19]
    output logic [dtp_pkg::M_TDATA_W-1:0] m_tdata,
    output logic                          m_tlast
);
    import dtp_pkg::*;

    tile_push_t tile_push;
    tile_t      head_tile;
    logic       queue_full;
    logic       head_valid;
    logic       pop;

    // front end
    dtp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .queue_full (queue_full),
        .tile_push  (tile_push)
    );

    // tile queue
    dtp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_push  (tile_push),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_tile  (head_tile),
        .pop        (pop)
    );

    // back end
    dtp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_tile  (head_tile),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    // a finished tile never meets a full queue
    `DTP_ASSERT_IMP(a_push_has_room, tile_push.valid, !queue_full, "tile pushed into full queue")
    // the input stalls only for lack of a queue slot
    `DTP_ASSERT_IMP(a_stall_cause, !s_tready, queue_full, "input stalled with queue room")
    // a pushed tile is visible at the queue head next cycle
    `DTP_ASSERT_NXT(a_push_visible, tile_push.valid, head_valid, "pushed tile not visible")
    // the column that closes a tile is the last column
    `DTP_ASSERT_IMP(a_last_col, m_tvalid && m_tlast, m_tdata[2:0] == LAST_COL,
        "tlast on wrong column")

endmodule
